// ===== hdl/mme_pkg.sv =====
`default_nettype none

package mme_pkg;

  // Sizes of the stores and the datapath
  localparam int MAX_DIM    = 64;
  localparam int DATA_WIDTH = 16;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int ACC_W      = 40;
  localparam int CFG_IDX_W  = 2;

  // Command codes
  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  // Tag that travels with each multiply-accumulate term
  typedef struct packed {
    logic             first_term;
    logic             last_term;
    logic             last_col;
    logic [IDX_W-1:0] col;
  } mac_tag_t;

  // Map zero to one and anything above MAX_DIM to MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mme_ram.sv =====
`default_nettype none

module mme_ram #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_BITS-1:0] waddr_i,
  input  wire logic [DATA_BITS-1:0] wdata_i,
  input  wire logic                 re_i,
  input  wire logic [ADDR_BITS-1:0] raddr_i,
  output logic      [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mme_mac.sv =====
`default_nettype none

module mme_mac (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    in_valid_i,
  input  wire logic signed [mme_pkg::DATA_WIDTH-1:0]   a_i,
  input  wire logic signed [mme_pkg::DATA_WIDTH-1:0]   b_i,
  input  wire mme_pkg::mac_tag_t                       tag_i,
  output logic                                         out_valid_o,
  output logic signed [mme_pkg::ACC_W-1:0]             out_value_o,
  output logic        [mme_pkg::IDX_W-1:0]             out_col_o,
  output logic                                         out_last_o
);

  import mme_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  mac_tag_t                 ptag_q;
  logic                     pvalid_q;
  logic        [ACC_W-1:0]  acc_q;
  logic        [ACC_W-1:0]  acc_base;
  logic        [ACC_W-1:0]  sum_d;

  // Product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else begin
      pvalid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      prod_q <= a_i * b_i;
      ptag_q <= tag_i;
    end
  end

  // Accumulate; restart on the first term of each column
  assign acc_base = ptag_q.first_term ? '0 : acc_q;
  assign sum_d    = acc_base + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    if (pvalid_q) begin
      acc_q <= sum_d;
    end
  end

  // Present each finished dot product for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= pvalid_q && ptag_q.last_term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pvalid_q && ptag_q.last_term) begin
      out_value_o <= sum_d;
      out_col_o   <= ptag_q.col;
      out_last_o  <= ptag_q.last_col;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/matrix_multiply_engine_unit.sv =====
`default_nettype none

// Dense matrix multiply C = A x B in fixed point, operands signed Q8.8.
// Command channel: a transaction is taken at a clock edge with start_i high
// and busy_o low. Opcode write A / write B stores elem_value_i at
// (row_index_i, col_index_i); busy_o stays low, so writes can
// follow every cycle. Opcode compute with row_index_i below rows_a runs
// the whole row of C; other compute rows and the unused opcode do nothing.
// A row runs on one shared multiply-accumulate unit fed from the two element
// memories, through the pipeline stages memory read, product and accumulate.
// Each result is shown for one cycle with valid_o high, in column order,
// last_in_row_o marking the final column; the receiver cannot stall it.
// busy_o drops the cycle after the last result. Configuration writes
// (cfg_we_i) take effect at once and must only be made while idle.
// Reset sets all three sizes to 64; the memory contents stay undefined
// until written.
module matrix_multiply_engine_unit (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  output logic                                        busy_o,
  input  wire logic [1:0]                             opcode_i,
  input  wire logic [mme_pkg::IDX_W-1:0]              row_index_i,
  input  wire logic [mme_pkg::IDX_W-1:0]              col_index_i,
  input  wire logic signed [mme_pkg::DATA_WIDTH-1:0]  elem_value_i,
  input  wire logic                                   cfg_we_i,
  input  wire logic [mme_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [mme_pkg::DIM_W-1:0]              cfg_data_i,
  output logic                                        valid_o,
  output logic signed [mme_pkg::ACC_W-1:0]            c_value_o,
  output logic [mme_pkg::IDX_W-1:0]                   c_row_o,
  output logic [mme_pkg::IDX_W-1:0]                   c_col_o,
  output logic                                        last_in_row_o
);

  import mme_pkg::*;

  state_e             state_q, state_d;
  logic [DIM_W-1:0]   rows_a_q, inner_dim_q, cols_b_q;
  logic [IDX_W-1:0]   row_q, t_q, j_q;
  logic               accept;
  logic               start_compute;
  logic               issue;
  logic               last_t, last_j;
  logic               we_a, we_b;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] rdata_a, rdata_b;
  logic               rvalid_q;
  mac_tag_t           tag_q;
  logic               mac_valid;
  logic               mac_last;

  assign accept        = start_i && !busy_o;
  assign start_compute = accept && (opcode_i == OP_COMPUTE) &&
                         ({1'b0, row_index_i} < rows_a_q);

  // Configuration registers, clamped on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_W'(MAX_DIM);
      inner_dim_q <= DIM_W'(MAX_DIM);
      cols_b_q    <= DIM_W'(MAX_DIM);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROWS_A:    rows_a_q    <= clamp_dim(cfg_data_i);
        REG_INNER_DIM: inner_dim_q <= clamp_dim(cfg_data_i);
        REG_COLS_B:    cols_b_q    <= clamp_dim(cfg_data_i);
        default:       ;
      endcase
    end
  end

  // Element stores
  assign we_a    = accept && (opcode_i == OP_WRITE_A);
  assign we_b    = accept && (opcode_i == OP_WRITE_B);
  assign waddr   = {row_index_i, col_index_i};
  assign raddr_a = {row_q, t_q};
  assign raddr_b = {t_q, j_q};

  mme_ram #(
    .ADDR_BITS (ADDR_W),
    .DATA_BITS (DATA_WIDTH)
  ) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (elem_value_i),
    .re_i    (issue),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mme_ram #(
    .ADDR_BITS (ADDR_W),
    .DATA_BITS (DATA_WIDTH)
  ) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (elem_value_i),
    .re_i    (issue),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // Term and column position
  assign last_t = ({1'b0, t_q} == inner_dim_q - DIM_W'(1));
  assign last_j = ({1'b0, j_q} == cols_b_q - DIM_W'(1));

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and read issue
  always_comb begin
    state_d = state_q;
    issue   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_compute) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (last_t && last_j) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_valid && mac_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // Advance term and column counters; capture the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q <= '0;
      j_q <= '0;
    end else if (start_compute) begin
      t_q <= '0;
      j_q <= '0;
    end else if (issue) begin
      if (last_t) begin
        t_q <= '0;
        j_q <= j_q + IDX_W'(1);
      end else begin
        t_q <= t_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_compute) begin
      row_q <= row_index_i;
    end
  end

  // Align the tag with the memory read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      tag_q.first_term <= (t_q == '0);
      tag_q.last_term  <= last_t;
      tag_q.last_col   <= last_j;
      tag_q.col        <= j_q;
    end
  end

  mme_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rvalid_q),
    .a_i         (rdata_a),
    .b_i         (rdata_b),
    .tag_i       (tag_q),
    .out_valid_o (mac_valid),
    .out_value_o (c_value_o),
    .out_col_o   (c_col_o),
    .out_last_o  (mac_last)
  );

  assign valid_o       = mac_valid;
  assign last_in_row_o = mac_last;
  assign c_row_o       = row_q;

`ifndef SYNTHESIS
  // A result only appears while a row is in progress
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result strobe while idle");

  // The final column releases the block
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_in_row_o) |=> !busy_o)
    else $error("still busy after last result");

  // Earlier columns keep the block busy
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_in_row_o) |=> busy_o)
    else $error("idle before last result");

  // Busy is entered only through an accepted command
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy without command");
`endif

endmodule

`default_nettype wire
